/* hdl/rdf_pkg.sv */
// Shared types and constants for the relay duplicate filter.
// No dependencies; imported by every file in hdl/ but rdf_ram.
package rdf_pkg;

    localparam int TABLE_ENTRIES = 20;
    localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
    localparam int IDX_W         = SLOT_W + 1;

    localparam int SERIAL_W      = 48;
    localparam int COUNT_W       = 31;
    localparam int ENTRY_W       = SERIAL_W + COUNT_W;
    localparam int SLOT_FIELD_W  = 5;

    localparam int PADDR_W       = 4;
    localparam int PDATA_W       = 64;
    localparam int REG_SEL_BIT   = 3;

    typedef enum logic {
        REG_RELAY_ENABLE,
        REG_OWN_SERIAL
    } t_reg_idx;

    typedef enum logic [1:0] {
        DEC_DISABLED,
        DEC_OWN,
        DEC_STALE,
        DEC_FORWARD
    } t_decision;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              load_item;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              cmp_en;
        logic [SLOT_W-1:0] cmp_idx;
        logic              update;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic out_stall;
    } t_sts;

endpackage

/* hdl/rdf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module rdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/rdf_regs.sv */
// APB-style configuration registers: relay enable and own serial.
// Depends on rdf_pkg.
module rdf_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rdf_pkg::PADDR_W-1:0]  paddr,
    input  logic [rdf_pkg::PDATA_W-1:0]  pwdata,
    output logic [rdf_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output logic                         o_relay_enable,
    output logic [rdf_pkg::SERIAL_W-1:0] o_own_serial
);
    import rdf_pkg::*;

    logic                r_relay_enable;
    logic [SERIAL_W-1:0] r_own_serial;
    t_reg_idx            reg_sel;
    logic                wr_en;

    // Low address bits are the byte offset within a 64-bit register.
    assign reg_sel = t_reg_idx'(paddr[REG_SEL_BIT]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay_enable <= 1'b0;
            r_own_serial   <= '0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_RELAY_ENABLE: r_relay_enable <= pwdata[0];
                REG_OWN_SERIAL:   r_own_serial   <= pwdata[SERIAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_RELAY_ENABLE: prdata = PDATA_W'(r_relay_enable);
            REG_OWN_SERIAL:   prdata = PDATA_W'(r_own_serial);
            default:          prdata = '0;
        endcase
    end

    assign o_relay_enable = r_relay_enable;
    assign o_own_serial   = r_own_serial;

endmodule

/* hdl/rdf_ctrl.sv */
// Transaction sequencer: latch, check, scan and update or skip, result.
// Depends on rdf_pkg.
module rdf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rdf_pkg::t_sts i_sts,
    output rdf_pkg::t_cmd o_cmd
);
    import rdf_pkg::*;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_cmp_pend, n_cmp_pend;
    logic [SLOT_W-1:0] r_cmp_idx, n_cmp_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idx      <= '0;
            r_cmp_pend <= 1'b0;
            r_cmp_idx  <= '0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_cmp_pend <= n_cmp_pend;
            r_cmp_idx  <= n_cmp_idx;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_cmp_pend    = 1'b0;
        n_cmp_idx     = r_cmp_idx;
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.rd_addr = r_idx[SLOT_W-1:0];
        // Read data of the previous cycle's address is compared this cycle.
        o_cmd.cmp_en  = r_cmp_pend;
        o_cmd.cmp_idx = r_cmp_idx;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_idx   = '0;
                n_state = i_sts.skip ? ST_DONE : ST_SCAN;
            end
            ST_SCAN: begin
                if (r_idx == IDX_W'(TABLE_ENTRIES)) begin
                    n_state = ST_UPDATE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_cmp_pend  = 1'b1;
                    n_cmp_idx   = r_idx[SLOT_W-1:0];
                    n_idx       = r_idx + 1'b1;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                // Hold the result until the output register can take it.
                if (!i_sts.out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

/* hdl/rdf_dpath.sv */
// Datapath: item latch, slot table with valid bits, scan trackers, output register.
// Depends on rdf_pkg and rdf_ram.
module rdf_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [rdf_pkg::SERIAL_W-1:0]     i_sender_serial,
    input  logic [rdf_pkg::COUNT_W-1:0]      i_packet_counter,
    input  logic                             i_relay_enable,
    input  logic [rdf_pkg::SERIAL_W-1:0]     i_own_serial,
    input  rdf_pkg::t_cmd                    i_cmd,
    output rdf_pkg::t_sts                    o_sts,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic                             o_forward,
    output logic [1:0]                       o_decision,
    output logic [rdf_pkg::SLOT_FIELD_W-1:0] o_slot_used
);
    import rdf_pkg::*;

    logic [SERIAL_W-1:0]      r_ser;
    logic [COUNT_W-1:0]       r_cnt;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic                     r_hit;
    logic [SLOT_W-1:0]        r_hit_idx;
    logic [COUNT_W-1:0]       r_hit_cnt;
    logic                     r_free_found;
    logic [SLOT_W-1:0]        r_free_idx;

    logic                     r_out_valid;
    logic                     r_forward;
    t_decision                r_decision;
    logic [SLOT_FIELD_W-1:0]  r_slot;

    logic [ENTRY_W-1:0]       rd_data;
    logic [SERIAL_W-1:0]      rd_serial;
    logic [COUNT_W-1:0]       rd_count;
    logic                     rd_valid;
    logic                     is_own;
    logic                     newer;
    logic                     wr_en;
    logic [SLOT_W-1:0]        wr_slot;
    t_decision                decision;

    assign rd_serial = rd_data[ENTRY_W-1:COUNT_W];
    assign rd_count  = rd_data[COUNT_W-1:0];
    assign rd_valid  = r_valid[i_cmd.cmp_idx];

    assign is_own  = (r_ser == i_own_serial);
    // Unknown serial acts as counter -1, so anything is newer.
    assign newer   = !r_hit || (r_cnt > r_hit_cnt);
    assign wr_slot = r_hit        ? r_hit_idx  :
                     r_free_found ? r_free_idx : SLOT_W'(TABLE_ENTRIES - 1);
    assign wr_en   = i_cmd.update && newer;

    always_comb begin
        if (!i_relay_enable) begin
            decision = DEC_DISABLED;
        end else if (is_own) begin
            decision = DEC_OWN;
        end else if (newer) begin
            decision = DEC_FORWARD;
        end else begin
            decision = DEC_STALE;
        end
    end

    rdf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_slot),
        .i_wdata ({r_ser, r_cnt}),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_ser <= i_sender_serial;
            r_cnt <= i_packet_counter;
        end
        if (i_cmd.cmp_en && rd_valid && (rd_serial == r_ser) && !r_hit) begin
            r_hit_idx <= i_cmd.cmp_idx;
            r_hit_cnt <= rd_count;
        end
        if (i_cmd.cmp_en && !rd_valid && !r_free_found) begin
            r_free_idx <= i_cmd.cmp_idx;
        end
        if (i_cmd.out_load) begin
            r_forward  <= (decision == DEC_FORWARD);
            r_decision <= decision;
            r_slot     <= (decision == DEC_FORWARD) ? SLOT_FIELD_W'(wr_slot) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load_item) begin
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
            end else if (i_cmd.cmp_en) begin
                if (rd_valid && (rd_serial == r_ser)) begin
                    r_hit <= 1'b1;
                end
                if (!rd_valid) begin
                    r_free_found <= 1'b1;
                end
            end
            if (wr_en) begin
                r_valid[wr_slot] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.skip      = !i_relay_enable || is_own;
    assign o_sts.out_stall = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_forward   = r_forward;
    assign o_decision  = r_decision;
    assign o_slot_used = r_slot;

endmodule

/* hdl/relay_duplicate_filter.sv */
// Top level of the relay duplicate filter: registers, sequencer and datapath.
// Depends on rdf_pkg, rdf_regs, rdf_ctrl, rdf_dpath and rdf_ram.
//
//   channel   signals                                           role
//   in        i_in_valid / o_in_ready, sender serial, counter   received packet
//   out       o_out_valid / i_out_ready, forward, decision, slot relay verdict
//   cfg       psel penable pwrite paddr pwdata prdata pready    relay enable, own serial
//
// A transaction runs from accept through check, a scan of the slot table RAM at one
// read per cycle, update and result; a disabled relay or an own packet skips the scan
// and the update. One transaction is in flight at a time; the next accept can come
// in the cycle after the result is loaded.
// A finished result waits in the output register while the next one is accepted;
// the block stalls only when that register is still full at the end of the next one.
// Synchronous reset empties the table at once through its valid bits.
module relay_duplicate_filter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [rdf_pkg::SERIAL_W-1:0]     i_sender_serial,
    input  logic [rdf_pkg::COUNT_W-1:0]      i_packet_counter,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_forward,
    output logic [1:0]                       o_decision,
    output logic [rdf_pkg::SLOT_FIELD_W-1:0] o_slot_used,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rdf_pkg::PADDR_W-1:0]      paddr,
    input  logic [rdf_pkg::PDATA_W-1:0]      pwdata,
    output logic [rdf_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);
    import rdf_pkg::*;

    logic                relay_enable;
    logic [SERIAL_W-1:0] own_serial;
    t_cmd                cmd;
    t_sts                sts;

    rdf_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_relay_enable (relay_enable),
        .o_own_serial   (own_serial)
    );

    rdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rdf_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sender_serial  (i_sender_serial),
        .i_packet_counter (i_packet_counter),
        .i_relay_enable   (relay_enable),
        .i_own_serial     (own_serial),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_forward        (o_forward),
        .o_decision       (o_decision),
        .o_slot_used      (o_slot_used)
    );

endmodule

/* hdl/rdf_checker.sv */
// Port-level checks for relay_duplicate_filter, attached by bind.
// Depends on rdf_pkg.
module rdf_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic                             o_forward,
    input logic [1:0]                       o_decision,
    input logic [rdf_pkg::SLOT_FIELD_W-1:0] o_slot_used
);
    import rdf_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_forward) && $stable(o_decision) && $stable(o_slot_used))
        else $error("result changed while stalled");

    a_fwd_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_forward == (o_decision == DEC_FORWARD)))
        else $error("forward flag disagrees with decision");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_forward |-> (o_slot_used == '0))
        else $error("slot reported for a dropped packet");

    // One transaction in flight: no accept on the cycle after an accept.
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while a transaction is in flight");

endmodule

bind relay_duplicate_filter rdf_checker u_rdf_checker (.*);

/* tb/sv/rdf_verdict_checker.sv */
`timescale 1ns / 100ps
// Checker for the relay duplicate filter: watches the packet, verdict and register
// channels, predicts each verdict from its own copy of the slot table, and compares.
// Depends on rdf_pkg for widths, register indexes and decision codes.
module rdf_verdict_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [rdf_pkg::SERIAL_W-1:0]     i_sender_serial,
    input  logic [rdf_pkg::COUNT_W-1:0]      i_packet_counter,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic                             i_forward,
    input  logic [1:0]                       i_decision,
    input  logic [rdf_pkg::SLOT_FIELD_W-1:0] i_slot_used,
    input  logic                             i_psel,
    input  logic                             i_penable,
    input  logic                             i_pwrite,
    input  logic                             i_pready,
    input  logic [rdf_pkg::PADDR_W-1:0]      i_paddr,
    input  logic [rdf_pkg::PDATA_W-1:0]      i_pwdata,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_forwarded
);
    import rdf_pkg::*;

    typedef struct {
        logic                    forward;
        t_decision               decision;
        logic [SLOT_FIELD_W-1:0] slot;
    } t_verdict;

    t_verdict            expected_verdicts[$];
    logic [SERIAL_W-1:0] seen_serial [TABLE_ENTRIES];
    logic [COUNT_W-1:0]  seen_count  [TABLE_ENTRIES];
    bit                  seen_valid  [TABLE_ENTRIES];
    bit                  relay_on;
    logic [SERIAL_W-1:0] own_id;
    int                  fail_total = 0;
    int                  pending_total = 0;
    int                  forward_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;
    assign o_forwarded  = forward_total;

    task automatic report_mismatch(input string what, input logic [SLOT_FIELD_W-1:0] got,
                                   input logic [SLOT_FIELD_W-1:0] want);
        $display("%0t ns: verdict mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        fail_total++;
    endtask

    // Decide one packet and update the table the way the block must.
    function automatic t_verdict relay_verdict(input logic [SERIAL_W-1:0] ser,
                                               input logic [COUNT_W-1:0] cnt);
        t_verdict v;
        int       hit;
        int       slot;
        v.forward  = 1'b0;
        v.decision = DEC_DISABLED;
        v.slot     = '0;
        hit        = -1;
        slot       = TABLE_ENTRIES - 1;
        if (!relay_on) begin
            return v;
        end
        if (ser == own_id) begin
            v.decision = DEC_OWN;
            return v;
        end
        // scan downward so the lowest matching and lowest empty slots win
        for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
            if (seen_valid[k] && seen_serial[k] == ser) hit = k;
            if (!seen_valid[k]) slot = k;
        end
        if (hit >= 0 && cnt <= seen_count[hit]) begin
            v.decision = DEC_STALE;
            return v;
        end
        if (hit >= 0) slot = hit;
        seen_serial[slot] = ser;
        seen_count[slot]  = cnt;
        seen_valid[slot]  = 1'b1;
        v.forward  = 1'b1;
        v.decision = DEC_FORWARD;
        v.slot     = SLOT_FIELD_W'(slot);
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                seen_serial[k] = '0;
                seen_count[k]  = '0;
                seen_valid[k]  = 1'b0;
            end
            relay_on = 1'b0;
            own_id   = '0;
            expected_verdicts.delete();
        end else begin
            // retire the oldest verdict before queuing a new one
            if (i_out_valid && i_out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch("verdict with no packet waiting (decision)",
                                    SLOT_FIELD_W'(i_decision), '0);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (i_forward !== want.forward)
                        report_mismatch("forward", SLOT_FIELD_W'(i_forward),
                                        SLOT_FIELD_W'(want.forward));
                    if (i_decision !== want.decision)
                        report_mismatch("decision", SLOT_FIELD_W'(i_decision),
                                        SLOT_FIELD_W'(want.decision));
                    if (i_slot_used !== want.slot)
                        report_mismatch("slot_used", i_slot_used, want.slot);
                    if (want.forward) forward_total++;
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[REG_SEL_BIT]))
                    REG_RELAY_ENABLE: relay_on = i_pwdata[0];
                    REG_OWN_SERIAL:   own_id   = i_pwdata[SERIAL_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_verdicts.push_back(relay_verdict(i_sender_serial, i_packet_counter));
        end
        pending_total = expected_verdicts.size();
    end

endmodule

/* tb/sv/tb_relay_duplicate_filter.sv */
`timescale 1ns / 100ps
// Top of the relay duplicate filter testbench: clock, reset, packet and register stimulus.
// Depends on rdf_pkg, relay_duplicate_filter and rdf_verdict_checker.
module tb_relay_duplicate_filter;
    import rdf_pkg::*;

    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 3 * (TABLE_ENTRIES + 4);
    localparam int POOL_SIZE    = TABLE_ENTRIES + 4;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [SERIAL_W-1:0]     sender_serial;
    logic [COUNT_W-1:0]      packet_counter;
    logic                    out_valid;
    logic                    out_ready;
    logic                    forward;
    logic [1:0]              decision;
    logic [SLOT_FIELD_W-1:0] slot_used;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [PADDR_W-1:0]      paddr;
    logic [PDATA_W-1:0]      pwdata;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;

    int                  fail_count;
    int                  pending;
    int                  forwarded;
    int                  cycles = 0;
    int                  packets_sent = 0;
    int                  reg_writes = 0;
    bit                  idle_on;
    logic [SERIAL_W-1:0] own_id;
    logic [SERIAL_W-1:0] pool_serial [POOL_SIZE];
    logic [COUNT_W-1:0]  pool_count  [POOL_SIZE];

    relay_duplicate_filter u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_sender_serial  (sender_serial),
        .i_packet_counter (packet_counter),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_forward        (forward),
        .o_decision       (decision),
        .o_slot_used      (slot_used),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    rdf_verdict_checker u_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_sender_serial  (sender_serial),
        .i_packet_counter (packet_counter),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_forward        (forward),
        .i_decision       (decision),
        .i_slot_used      (slot_used),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_forwarded      (forwarded)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d verdicts outstanding", cycles, pending);
            $display("tb_relay_duplicate_filter: FAIL");
            $finish;
        end
    end

    // Verdict side: stall in random bursts while idling is on.
    initial begin
        out_ready = 1'b1;
        forever begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input t_reg_idx r, input logic [PDATA_W-1:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(int'(r) * 8);
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
    endtask

    // Leaves valid high on return so back-to-back packets stream without a gap.
    task automatic send_packet(input logic [SERIAL_W-1:0] ser, input logic [COUNT_W-1:0] cnt);
        int gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        sender_serial  <= ser;
        packet_counter <= cnt;
        do @(posedge clk); while (!(in_valid && in_ready));
        packets_sent++;
    endtask

    // Drop valid and wait for every verdict so the registers may change.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    function automatic logic [SERIAL_W-1:0] rand_serial();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Mostly a reused set of senders with advancing counters, some repeats and rollbacks,
    // plus strangers and our own serial. More senders than slots forces evictions.
    task automatic random_phase(input int n);
        int                  k;
        int                  roll;
        logic [SERIAL_W-1:0] ser;
        for (int j = 0; j < POOL_SIZE; j++) begin
            pool_serial[j] = rand_serial();
            pool_count[j]  = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                          : 31'($urandom_range(0, 50));
        end
        repeat (n) begin
            k    = $urandom_range(0, POOL_SIZE - 1);
            roll = $urandom_range(0, 99);
            ser  = pool_serial[k];
            if (roll < 5)
                ser = own_id;
            else if (roll < 12)
                ser = rand_serial();
            roll = $urandom_range(0, 99);
            if (roll < 60)
                pool_count[k] = pool_count[k] + 31'($urandom_range(1, 1000));
            else if (roll < 88 && roll >= 75)
                pool_count[k] = pool_count[k] - 31'($urandom_range(1, 50));
            else if (roll >= 88)
                pool_count[k] = 31'($urandom);
            send_packet(ser, pool_count[k]);
        end
    endtask

    initial begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        sender_serial  = '0;
        packet_counter = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        idle_on        = 1'b1;
        own_id         = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // relay off after reset
        send_packet('0, '0);
        send_packet('1, '1);
        settle();

        write_reg(REG_RELAY_ENABLE, 64'd1);
        write_reg(REG_OWN_SERIAL, {16'h0, 48'hFFFF_FFFF_FFFF});
        own_id = '1;
        send_packet('1, 31'd5);                          // own packet
        send_packet('0, '0);                             // zero serial is a real sender
        send_packet('0, '0);                             // equal counter, drop
        send_packet('0, 31'd1);
        send_packet('0, '0);                             // older counter, drop
        send_packet(48'h8000_0000_0001, 31'h7FFF_FFFF);
        send_packet(48'h8000_0000_0001, 31'h7FFF_FFFF);
        for (int k = 2; k < TABLE_ENTRIES; k++)
            send_packet(48'h5A00_0000_0000 | SERIAL_W'(k), COUNT_W'(k));
        // table full: newcomer lands in the last slot, evicting its owner
        send_packet(48'hA5A5_0000_0000, 31'd7);
        send_packet(48'h5A00_0000_0000 | SERIAL_W'(TABLE_ENTRIES - 1), '0);
        settle();

        write_reg(REG_OWN_SERIAL, '0);
        own_id = '0;
        send_packet('0, 31'd3);
        settle();

        own_id = rand_serial();
        write_reg(REG_OWN_SERIAL, {16'h0, own_id});
        random_phase(120);
        settle();

        write_reg(REG_RELAY_ENABLE, 64'd0);
        random_phase(40);
        settle();

        write_reg(REG_RELAY_ENABLE, 64'd1);
        write_reg(REG_OWN_SERIAL, '0);
        own_id = '0;
        random_phase(120);
        settle();

        own_id = rand_serial();
        write_reg(REG_OWN_SERIAL, {16'h0, own_id});
        idle_on = 1'b0;
        random_phase(100);
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d packets, %0d forwarded, across %0d register writes", packets_sent,
                 forwarded, reg_writes);
        $display("relay on and off, own serial at both extremes, table fill and eviction");
        if (fail_count == 0 && pending == 0) begin
            $display("tb_relay_duplicate_filter: PASS");
        end else begin
            $display("tb_relay_duplicate_filter: FAIL");
        end
        $finish;
    end

endmodule
